FILE: rtl/tlse_pkg.sv
// ----------------------------------------------------------------------------
// tlse_pkg
// Shared types and constants of the toroidal lattice exchange engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tlse_pkg;

    // Field widths of the item and the result
    localparam int MODE_W = 2;
    localparam int COORD_W = 6;
    localparam int DIR_W = 2;
    localparam int POP_W = 13;

    // Coordinates on the item port span this many codes
    localparam int COORD_CODES = 2 ** COORD_W;

    localparam int SIDE_DEFAULT = 64;

    // Operation codes; the unused code behaves as a read
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SWAP = 2'd2;

    // Exchange partner codes
    localparam logic [DIR_W-1:0] DIR_ROW_INC = 2'd0;
    localparam logic [DIR_W-1:0] DIR_COL_DEC = 2'd1;
    localparam logic [DIR_W-1:0] DIR_ROW_DEC = 2'd2;
    localparam logic [DIR_W-1:0] DIR_COL_INC = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [DIR_W-1:0]   direction;
        logic               value;
    } tlse_in_t;

    typedef struct packed {
        logic             read_value;
        logic             swapped;
        logic [POP_W-1:0] population;
    } tlse_out_t;

    typedef enum logic [1:0] {
        ADDR_CLR,
        ADDR_HERE,
        ADDR_THERE
    } tlse_addr_sel_t;

    typedef enum logic [1:0] {
        WD_ZERO,
        WD_VALUE,
        WD_RDATA,
        WD_HELD
    } tlse_wd_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic           load_item;
        logic           clr_step;
        logic           mem_re;
        logic           mem_we;
        tlse_addr_sel_t addr_sel;
        tlse_wd_sel_t   wd_sel;
        logic           cap_a;
        logic           cnt_upd;
        logic           emit;
    } tlse_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_write;
        logic is_swap;
        logic differ;
    } tlse_stat_t;

endpackage : tlse_pkg

`default_nettype wire

FILE: rtl/tlse_datapath.sv
// ----------------------------------------------------------------------------
// tlse_datapath
// Grid memory, item registers, neighbor address math, population counter
// and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlse_datapath #(
    parameter int SIDE = tlse_pkg::SIDE_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tlse_pkg::tlse_in_t   item,
    input  wire tlse_pkg::tlse_cmd_t  cmd,
    output tlse_pkg::tlse_stat_t      stat,
    output logic                      done,
    output tlse_pkg::tlse_out_t       result
);
    import tlse_pkg::*;

    localparam int CW = $clog2(SIDE);
    localparam int CELLS = SIDE * SIDE;
    localparam int AW = $clog2(CELLS);
    localparam logic [CW-1:0] LAST_COORD = CW'(SIDE - 1);
    localparam logic [AW-1:0] SIDE_A = AW'(SIDE);
    localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);

    // Port coordinate folded modulo SIDE
    logic [CW-1:0] coord_lut [COORD_CODES];

    for (genvar g = 0; g < COORD_CODES; g++) begin : g_lut
        localparam int Wrapped = g % SIDE;
        assign coord_lut[g] = CW'(Wrapped);
    end

    logic [MODE_W-1:0] mode_reg;
    logic [CW-1:0]     row_reg;
    logic [CW-1:0]     col_reg;
    logic [DIR_W-1:0]  dir_reg;
    logic              val_reg;
    logic              a_reg;
    logic              rdata_reg;
    logic [AW-1:0]     clr_addr_reg;
    logic [POP_W-1:0]  count_reg;
    logic [POP_W-1:0]  count_next;
    logic              done_reg;
    tlse_out_t         result_reg;

    logic cell_mem [CELLS];

    logic [CW-1:0] row_nb;
    logic [CW-1:0] col_nb;
    logic [AW-1:0] here_addr;
    logic [AW-1:0] there_addr;
    logic [AW-1:0] mem_addr;
    logic          mem_wdata;
    logic          is_write;
    logic          is_swap;

    assign is_write = (mode_reg == MODE_WRITE);
    assign is_swap = (mode_reg == MODE_SWAP);

    // Wrapping neighbor
    always_comb begin
        row_nb = row_reg;
        col_nb = col_reg;
        case (dir_reg)
            DIR_ROW_INC: row_nb = (row_reg == LAST_COORD) ? '0 : row_reg + CW'(1);
            DIR_COL_DEC: col_nb = (col_reg == '0) ? LAST_COORD : col_reg - CW'(1);
            DIR_ROW_DEC: row_nb = (row_reg == '0) ? LAST_COORD : row_reg - CW'(1);
            DIR_COL_INC: col_nb = (col_reg == LAST_COORD) ? '0 : col_reg + CW'(1);
            default:     row_nb = row_reg;
        endcase
    end

    assign here_addr = AW'(row_reg) * SIDE_A + AW'(col_reg);
    assign there_addr = AW'(row_nb) * SIDE_A + AW'(col_nb);

    always_comb begin
        case (cmd.addr_sel)
            ADDR_CLR:   mem_addr = clr_addr_reg;
            ADDR_HERE:  mem_addr = here_addr;
            ADDR_THERE: mem_addr = there_addr;
            default:    mem_addr = here_addr;
        endcase
    end

    always_comb begin
        case (cmd.wd_sel)
            WD_ZERO:  mem_wdata = 1'b0;
            WD_VALUE: mem_wdata = val_reg;
            WD_RDATA: mem_wdata = rdata_reg;
            WD_HELD:  mem_wdata = a_reg;
            default:  mem_wdata = 1'b0;
        endcase
    end

    // Population follows a cell write that flips the old value
    always_comb begin
        count_next = count_reg;
        if (cmd.cnt_upd && (val_reg != rdata_reg)) begin
            count_next = val_reg ? count_reg + POP_W'(1) : count_reg - POP_W'(1);
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.mem_we) begin
            cell_mem[mem_addr] <= mem_wdata;
        end
        if (cmd.mem_re) begin
            rdata_reg <= cell_mem[mem_addr];
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load_item) begin
            mode_reg <= item.mode;
            row_reg  <= coord_lut[item.row];
            col_reg  <= coord_lut[item.col];
            dir_reg  <= item.direction;
            val_reg  <= item.value;
        end
        if (cmd.cap_a) begin
            a_reg <= rdata_reg;
        end
        if (cmd.emit) begin
            result_reg.read_value <= is_write ? val_reg : rdata_reg;
            result_reg.swapped    <= is_swap && (a_reg != rdata_reg);
            result_reg.population <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clr_addr_reg <= '0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
        end else begin
            if (cmd.clr_step) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            count_reg <= count_next;
            done_reg  <= cmd.emit;
        end
    end

    assign stat.clr_last = (clr_addr_reg == LAST_ADDR);
    assign stat.is_write = is_write;
    assign stat.is_swap  = is_swap;
    assign stat.differ   = (a_reg != rdata_reg);

    assign done = done_reg;
    assign result = result_reg;

    // Single port: never read and write in one cycle
    a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_we |-> !cmd.mem_re)
        else $error("grid memory read and written in the same cycle");

    // One strobe per item, never two in a row
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // Population moves by at most one per cycle
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg))
              || (count_reg == POP_W'($past(count_reg) + POP_W'(1)))
              || (count_reg == POP_W'($past(count_reg) - POP_W'(1))))
        else $error("population jumped by more than one");

    // Exchanges never change the population
    a_swap_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && is_swap) |=> $stable(count_reg))
        else $error("population changed by an exchange");

endmodule : tlse_datapath

`default_nettype wire

FILE: rtl/tlse_ctrl.sv
// ----------------------------------------------------------------------------
// tlse_ctrl
// Sequencer: clearing pass after reset, then one item at a time through
// the single-port grid memory.
// ----------------------------------------------------------------------------
`default_nettype none

module tlse_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire tlse_pkg::tlse_stat_t stat,
    output tlse_pkg::tlse_cmd_t       cmd
);
    import tlse_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_SW_A,
        S_SW_B,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.addr_sel = ADDR_HERE;
        cmd.wd_sel   = WD_ZERO;
        case (state_reg)
            S_CLEAR: begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = ADDR_CLR;
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_RD_A;
                end
            end
            S_RD_A: begin
                cmd.mem_re = 1'b1;
                state_next = stat.is_swap ? S_RD_B : S_EXEC;
            end
            S_RD_B: begin
                cmd.mem_re   = 1'b1;
                cmd.addr_sel = ADDR_THERE;
                cmd.cap_a    = 1'b1;
                state_next   = S_SW_A;
            end
            S_SW_A: begin
                // Binary cells that differ: each takes the other's value
                cmd.emit = 1'b1;
                if (stat.differ) begin
                    cmd.mem_we = 1'b1;
                    cmd.wd_sel = WD_RDATA;
                    state_next = S_SW_B;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_SW_B: begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = ADDR_THERE;
                cmd.wd_sel   = WD_HELD;
                state_next   = S_IDLE;
            end
            S_EXEC: begin
                cmd.emit = 1'b1;
                if (stat.is_write) begin
                    cmd.mem_we  = 1'b1;
                    cmd.wd_sel  = WD_VALUE;
                    cmd.cnt_upd = 1'b1;
                end
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // An accepted item makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    // Every item ends with exactly one result emitted before idle
    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (state_reg == S_EXEC || state_reg == S_SW_A))
        else $error("result emitted outside a finishing state");

endmodule : tlse_ctrl

`default_nettype wire

FILE: rtl/toroidal_lattice_swap_engine.sv
// ----------------------------------------------------------------------------
// toroidal_lattice_swap_engine
// SIDE x SIDE torus of one-bit cells with a running population count:
// write a cell, read a cell, or exchange a cell with a wrapping neighbor.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy is low. Each item
// gives exactly one result, shown on result while done is high for a single
// cycle; there is no back-pressure, so the receiver must take it then.
// After reset the block runs a clearing pass that writes zero to every cell
// of the grid memory, with busy high. From then on a write or a read reads
// its cell (S_RD_A) and then, in S_EXEC, writes it for a write and emits the
// result; an exchange proposal reads both cells (S_RD_A, S_RD_B), emits the
// result in S_SW_A and, when the cells differ, writes both back (S_SW_A,
// S_SW_B), one port access at a time, as the grid memory is single-port
// with a registered read. A new item is taken only once the sequencer is
// idle again; done is registered from the emitting state.
// ----------------------------------------------------------------------------
`default_nettype none

module toroidal_lattice_swap_engine #(
    parameter int SIDE = tlse_pkg::SIDE_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire tlse_pkg::tlse_in_t item,
    output logic                    done,
    output tlse_pkg::tlse_out_t     result
);
    import tlse_pkg::*;

    // Command and status between sequencer and datapath
    tlse_cmd_t  cmd;
    tlse_stat_t stat;

    // Sequencer: clearing pass, then read/modify/write steps per transfer
    tlse_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Grid memory, coordinate wrap, population counter, result register
    tlse_datapath #(
        .SIDE (SIDE)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

endmodule : toroidal_lattice_swap_engine

`default_nettype wire
